>>> rtl/bdch_pkg.sv
// Package for the three-button debouncer with click and hold events.
// Holds the shared types, register codes and reset values; no dependencies.
package bdch_pkg;

   localparam int NUM_BUTTONS  = 3;
   localparam int NOW_WIDTH    = 32;
   localparam int CFG_WIDTH    = 16;
   localparam int MASK_WIDTH   = 3;
   localparam int INDEX_WIDTH  = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 8;

   localparam logic [CFG_WIDTH-1:0]  DEBOUNCE_RESET = 16'd30;
   localparam logic [CFG_WIDTH-1:0]  HOLD_RESET     = 16'd3000;
   localparam logic [CFG_WIDTH-1:0]  LOCKOUT_RESET  = 16'd50;
   localparam logic [MASK_WIDTH-1:0] HOLD_EN_RESET  = 3'd1;
   localparam logic [MASK_WIDTH-1:0] LOCK_EN_RESET  = 3'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE = 3'd0,
      CSR_HOLD     = 3'd1,
      CSR_LOCKOUT  = 3'd2,
      CSR_HOLD_EN  = 3'd3,
      CSR_LOCK_EN  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] hold_ms;
      logic [CFG_WIDTH-1:0] lockout_ms;
      logic                 hold_en;
      logic                 lockout_en;
   } lane_cfg_type;

   typedef struct packed {
      logic valid;
      logic hold;
   } event_type;

endpackage

>>> rtl/bdch_lane.sv
// One button lane: debounce, press timing, hold detection and lockout.
// Depends on bdch_pkg for the lane configuration and event types.
module bdch_lane #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  raw,
   input  logic [TIME_WIDTH-1:0] now_time,
   input  bdch_pkg::lane_cfg_type cfg,
   output bdch_pkg::event_type   evt
);
   import bdch_pkg::*;

   logic                  sampled_ff, sampled_in;
   logic                  stable_ff, stable_in;
   logic                  hold_done_ff, hold_done_in;
   logic [TIME_WIDTH-1:0] edge_time_ff, edge_time_in;
   logic [TIME_WIDTH-1:0] press_time_ff, press_time_in;
   logic [TIME_WIDTH-1:0] last_accept_ff, last_accept_in;

   logic                  changed;
   logic [TIME_WIDTH-1:0] edge_elapsed;
   logic [TIME_WIDTH-1:0] press_elapsed;
   logic [TIME_WIDTH-1:0] accept_elapsed;
   logic                  lock_ok;
   logic                  offer;
   logic                  offer_hold;
   logic                  emit;

   always_comb begin
      changed        = raw != sampled_ff;
      sampled_in     = raw;
      edge_time_in   = changed ? now_time : edge_time_ff;
      edge_elapsed   = changed ? '0 : now_time - edge_time_ff;
      press_elapsed  = now_time - press_time_ff;
      accept_elapsed = now_time - last_accept_ff;
      lock_ok        = !cfg.lockout_en ||
                       (accept_elapsed >= TIME_WIDTH'(cfg.lockout_ms));

      stable_in      = stable_ff;
      hold_done_in   = hold_done_ff;
      press_time_in  = press_time_ff;
      last_accept_in = last_accept_ff;
      offer          = 1'b0;
      offer_hold     = 1'b0;

      if (raw == stable_ff) begin
         if (!stable_ff && cfg.hold_en && !hold_done_ff &&
             (press_elapsed >= TIME_WIDTH'(cfg.hold_ms))) begin
            offer        = 1'b1;
            offer_hold   = 1'b1;
            hold_done_in = 1'b1;
         end
      end else if (edge_elapsed >= TIME_WIDTH'(cfg.debounce_ms)) begin
         stable_in = raw;
         if (!raw) begin
            press_time_in = now_time;
            hold_done_in  = 1'b0;
         end else if (!hold_done_ff) begin
            offer = 1'b1;
         end
      end

      // A dropped event on a lockout button leaves the accept time alone.
      emit = offer && lock_ok;
      if (emit && cfg.lockout_en) begin
         last_accept_in = now_time;
      end

      evt.valid = emit;
      evt.hold  = offer_hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff     <= 1'b1;
         stable_ff      <= 1'b1;
         hold_done_ff   <= 1'b0;
         edge_time_ff   <= '0;
         press_time_ff  <= '0;
         last_accept_ff <= '0;
      end else if (load) begin
         sampled_ff     <= sampled_in;
         stable_ff      <= stable_in;
         hold_done_ff   <= hold_done_in;
         edge_time_ff   <= edge_time_in;
         press_time_ff  <= press_time_in;
         last_accept_ff <= last_accept_in;
      end
   end

endmodule

>>> rtl/bdch_merge.sv
// Merging stage: collects the events of one poll from the lanes and sends
// them out one per cycle while out_ready holds, in button order. Depends on bdch_pkg.
module bdch_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  bdch_pkg::event_type [bdch_pkg::NUM_BUTTONS-1:0] lane_evt,
   input  logic                                   out_ready,
   output logic                                   out_valid,
   output logic [bdch_pkg::INDEX_WIDTH-1:0]       out_index,
   output logic                                   out_hold,
   output logic                                   out_last,
   output logic                                   can_load
);
   import bdch_pkg::*;

   logic [NUM_BUTTONS-1:0] pending_ff, pending_in;
   logic [NUM_BUTTONS-1:0] kind_ff, kind_in;
   logic [NUM_BUTTONS-1:0] lowest;
   logic                   fire;

   always_comb begin
      lowest    = '0;
      out_index = '0;
      priority if (pending_ff[0]) begin
         lowest[0] = 1'b1;
         out_index = INDEX_WIDTH'(0);
      end else if (pending_ff[1]) begin
         lowest[1] = 1'b1;
         out_index = INDEX_WIDTH'(1);
      end else if (pending_ff[2]) begin
         lowest[2] = 1'b1;
         out_index = INDEX_WIDTH'(2);
      end else begin
         lowest    = '0;
         out_index = '0;
      end

      out_valid = |pending_ff;
      out_hold  = |(kind_ff & lowest);
      out_last  = (pending_ff & ~lowest) == '0;
      fire      = out_valid && out_ready;
      can_load  = !out_valid || (fire && out_last);

      kind_in    = kind_ff;
      pending_in = pending_ff;
      if (load) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            pending_in[b] = lane_evt[b].valid;
            kind_in[b]    = lane_evt[b].hold;
         end
      end else if (fire) begin
         pending_in = pending_ff & ~lowest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

endmodule

>>> rtl/button_debounce_click_hold.sv
// Top level of the three-button debouncer with click, hold and lockout.
// Instantiates three bdch_lane cores and bdch_merge; depends on bdch_pkg.
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_tvalid/tready     tdata: raw levels, now_ms
//  rsp      out        rsp_tvalid/tready     tdata: button_index, tuser, tlast
//  csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// All lanes update together when a poll is accepted. Its events leave one
// per cycle while rsp_tready is high; a new poll can be taken while the last
// event of the previous poll leaves the result port.
// Reset is synchronous: buttons start released, all times at zero.
// A stalled result port blocks new polls while any event of a poll waits.
module button_debounce_click_hold #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] raw_left, [1] raw_right, [2] raw_confirm, [34:3] now_ms
   input  logic [bdch_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] button_index
   output logic [bdch_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] is_hold
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bdch_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bdch_pkg::CFG_WIDTH-1:0]        csr_data
);
   import bdch_pkg::*;

   logic [CFG_WIDTH-1:0]  debounce_ff;
   logic [CFG_WIDTH-1:0]  hold_ff;
   logic [CFG_WIDTH-1:0]  lockout_ff;
   logic [MASK_WIDTH-1:0] hold_en_ff;
   logic [MASK_WIDTH-1:0] lock_en_ff;

   logic                  load;
   logic [TIME_WIDTH-1:0] now_time;
   logic [INDEX_WIDTH-1:0] out_index;
   lane_cfg_type [NUM_BUTTONS-1:0] lane_cfg;
   event_type    [NUM_BUTTONS-1:0] lane_evt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
         lockout_ff  <= LOCKOUT_RESET;
         hold_en_ff  <= HOLD_EN_RESET;
         lock_en_ff  <= LOCK_EN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            CSR_HOLD:     hold_ff     <= csr_data;
            CSR_LOCKOUT:  lockout_ff  <= csr_data;
            CSR_HOLD_EN:  hold_en_ff  <= csr_data[MASK_WIDTH-1:0];
            CSR_LOCK_EN:  lock_en_ff  <= csr_data[MASK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign load     = req_tvalid && req_tready;
   assign now_time = TIME_WIDTH'(req_tdata[NUM_BUTTONS +: NOW_WIDTH]);

   for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      assign lane_cfg[b].debounce_ms = debounce_ff;
      assign lane_cfg[b].hold_ms     = hold_ff;
      assign lane_cfg[b].lockout_ms  = lockout_ff;
      assign lane_cfg[b].hold_en     = hold_en_ff[b];
      assign lane_cfg[b].lockout_en  = lock_en_ff[b];

      bdch_lane #(
         .TIME_WIDTH (TIME_WIDTH)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .load     (load),
         .raw      (req_tdata[b]),
         .now_time (now_time),
         .cfg      (lane_cfg[b]),
         .evt      (lane_evt[b])
      );
   end

   bdch_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .lane_evt  (lane_evt),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_index (out_index),
      .out_hold  (rsp_tuser),
      .out_last  (rsp_tlast),
      .can_load  (req_tready)
   );

   assign rsp_tdata = RSP_DATA_W'(out_index);

endmodule

>>> rtl/bdch_checker.sv
// Port-level checks for the debouncer top level, bound to every instance.
// Depends on bdch_pkg for port widths.
module bdch_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bdch_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import bdch_pkg::*;

   // A stalled result keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A new request waits while more than one event of a poll is still out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken before the poll was drained");

   // Events of one poll leave in rising button order.
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[1:0] > $past(rsp_tdata[1:0])))
      else $error("events out of button order");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("button index out of range");

endmodule

bind button_debounce_click_hold bdch_checker u_bdch_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> bench/tb.sv
// Testbench for button_debounce_click_hold: directed and random polls, checked
// against a cycle-free predictor of the three button debouncers.
// Depends on bdch_pkg and the button_debounce_click_hold top level.
module tb;
   import bdch_pkg::*;

   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_CSR = CSR_IDX_W'(CSR_LOCK_EN + 1);

   typedef struct {
      logic [INDEX_WIDTH-1:0] button;
      logic                   hold;
      logic                   last;
   } press_event_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CFG_WIDTH-1:0]   csr_data = '0;

   // Predictor state and its copy of the registers.
   logic [CFG_WIDTH-1:0]   cfg_debounce;
   logic [CFG_WIDTH-1:0]   cfg_hold;
   logic [CFG_WIDTH-1:0]   cfg_lockout;
   logic [MASK_WIDTH-1:0]  cfg_hold_en;
   logic [MASK_WIDTH-1:0]  cfg_lock_en;
   logic [NUM_BUTTONS-1:0] lvl_sampled;
   logic [NUM_BUTTONS-1:0] lvl_stable;
   logic [NUM_BUTTONS-1:0] held_flag;
   logic [NOW_WIDTH-1:0]   t_edge [NUM_BUTTONS];
   logic [NOW_WIDTH-1:0]   t_press [NUM_BUTTONS];
   logic [NOW_WIDTH-1:0]   t_accepted [NUM_BUTTONS];

   press_event_type        expected_events [$];
   int                     mismatches = 0;
   int                     idle_cycles = 0;
   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     hold_off_ticket = 0;
   int                     served_ticket = 0;
   int                     stall_left = 0;
   logic [NOW_WIDTH-1:0]   poll_clock_ms = '0;

   button_debounce_click_hold uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic clear_predictor();
      cfg_debounce = DEBOUNCE_RESET;
      cfg_hold     = HOLD_RESET;
      cfg_lockout  = LOCKOUT_RESET;
      cfg_hold_en  = HOLD_EN_RESET;
      cfg_lock_en  = LOCK_EN_RESET;
      lvl_sampled  = '1;
      lvl_stable   = '1;
      held_flag    = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         t_edge[b]     = '0;
         t_press[b]    = '0;
         t_accepted[b] = '0;
      end
      expected_events.delete();
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_WIDTH-1:0] value);
      unique case (idx)
         CSR_DEBOUNCE: cfg_debounce = value;
         CSR_HOLD:     cfg_hold     = value;
         CSR_LOCKOUT:  cfg_lockout  = value;
         CSR_HOLD_EN:  cfg_hold_en  = value[MASK_WIDTH-1:0];
         CSR_LOCK_EN:  cfg_lock_en  = value[MASK_WIDTH-1:0];
         default: ;
      endcase
   endtask

   function automatic bit lockout_clear(input int b, input logic [NOW_WIDTH-1:0] stamp);
      logic [NOW_WIDTH-1:0] since;
      since = stamp - t_accepted[b];
      if (!cfg_lock_en[b])
         return 1'b1;
      if (since < cfg_lockout)
         return 1'b0;
      t_accepted[b] = stamp;
      return 1'b1;
   endfunction

   task automatic predict_button_events(input logic [REQ_DATA_W-1:0] data);
      logic [NOW_WIDTH-1:0] stamp;
      int                   first_new;
      stamp = data[NUM_BUTTONS +: NOW_WIDTH];
      first_new = expected_events.size();
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (data[b] != lvl_sampled[b]) begin
            lvl_sampled[b] = data[b];
            t_edge[b] = stamp;
         end
         if (lvl_sampled[b] == lvl_stable[b]) begin
            if (!lvl_stable[b] && cfg_hold_en[b] && !held_flag[b] &&
                ((stamp - t_press[b]) >= cfg_hold)) begin
               if (lockout_clear(b, stamp))
                  expected_events.push_back('{button: INDEX_WIDTH'(b), hold: 1'b1,
                                              last: 1'b0});
               held_flag[b] = 1'b1;
            end
         end else if ((stamp - t_edge[b]) >= cfg_debounce) begin
            lvl_stable[b] = lvl_sampled[b];
            if (!lvl_stable[b]) begin
               t_press[b] = stamp;
               held_flag[b] = 1'b0;
            end else if (!held_flag[b] && lockout_clear(b, stamp)) begin
               expected_events.push_back('{button: INDEX_WIDTH'(b), hold: 1'b0,
                                           last: 1'b0});
            end
         end
      end
      if (expected_events.size() > first_new)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      press_event_type want;
      if (reset) begin
         clear_predictor();
      end else begin
         if (csr_valid && csr_ready)
            apply_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            predict_button_events(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result: button_index %0d is_hold %0d last_event %0d",
                      rsp_tdata[INDEX_WIDTH-1:0], rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[INDEX_WIDTH-1:0] !== want.button) begin
                  $error("button_index: expected %0d, actual %0d", want.button,
                         rsp_tdata[INDEX_WIDTH-1:0]);
                  mismatches++;
               end
               if (rsp_tuser !== want.hold) begin
                  $error("is_hold: expected %0d, actual %0d", want.hold, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_event: expected %0d, actual %0d", want.last, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_off_ticket != served_ticket) begin
         served_ticket = hold_off_ticket;
         stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_poll(input logic [NUM_BUTTONS-1:0] levels,
                            input logic [NOW_WIDTH-1:0] stamp);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({stamp, levels});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Level vectors are {confirm, right, left}; a zero bit is a pressed button.
   task automatic test_lockout_after_reset();
      write_reg(CSR_DEBOUNCE, 16'd0);
      send_poll(3'b011, 32'd5);
      send_poll(3'b111, 32'd10);
   endtask

   task automatic test_hold_and_click();
      send_poll(3'b110, 32'd20);
      send_poll(3'b110, 32'd3019);
      send_poll(3'b100, 32'd3020);
      send_poll(3'b111, 32'd3030);
      send_poll(3'b011, 32'd3100);
      send_poll(3'b111, 32'd3101);
      send_poll(3'b011, 32'd3120);
      send_poll(3'b111, 32'd3130);
   endtask

   task automatic test_suppressed_hold();
      write_reg(CSR_HOLD, 16'd0);
      write_reg(CSR_LOCKOUT, 16'hFFFF);
      write_reg(CSR_HOLD_EN, 16'd7);
      send_poll(3'b011, 32'd3200);
      send_poll(3'b011, 32'd3201);
      send_poll(3'b111, 32'd3202);
      send_poll(3'b110, 32'd3203);
      send_poll(3'b110, 32'd3204);
      send_poll(3'b111, 32'd3205);
   endtask

   task automatic test_time_wrap();
      write_reg(CSR_DEBOUNCE, 16'd20);
      write_reg(CSR_LOCKOUT, 16'd0);
      write_reg(CSR_HOLD, 16'hFFFF);
      send_poll(3'b000, 32'hFFFF_FFF0);
      send_poll(3'b000, 32'h0000_0004);
      send_poll(3'b000, 32'h0001_0002);
      send_poll(3'b000, 32'h0001_0003);
      send_poll(3'b111, 32'hFFFF_FFFF);
      send_poll(3'b111, 32'h0000_0013);
      write_reg(CSR_DEBOUNCE, 16'hFFFF);
      send_poll(3'b110, 32'd100);
      send_poll(3'b110, 32'd65634);
      send_poll(3'b110, 32'd65635);
   endtask

   task automatic test_register_masking();
      write_reg(CSR_HOLD_EN, 16'hFFF8);
      write_reg(CSR_DEBOUNCE, 16'd0);
      for (int i = FIRST_UNUSED_CSR; i < 2 ** CSR_IDX_W; i++)
         write_reg(CSR_IDX_W'(i), 16'h0007);
      send_poll(3'b111, 32'd1000);
      send_poll(3'b110, 32'd1001);
      send_poll(3'b110, 32'd200000);
      send_poll(3'b111, 32'd200001);
   endtask

   function automatic logic [CFG_WIDTH-1:0] pick_span();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CFG_WIDTH'($urandom_range(0, 120));
      endcase
   endfunction

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int polls);
      logic [NUM_BUTTONS-1:0] levels;
      int unsigned            reach;
      int                     pick;
      write_reg(CSR_DEBOUNCE, pick_span());
      write_reg(CSR_HOLD, pick_span());
      write_reg(CSR_LOCKOUT, pick_span());
      write_reg(CSR_HOLD_EN, CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
      write_reg(CSR_LOCK_EN, CFG_WIDTH'($urandom_range(0, 16'hFFFF)));
      set_idling(send_pct, recv_pct);
      poll_clock_ms = $urandom();
      levels = '1;
      repeat (polls) begin
         if ($urandom_range(0, 9) == 0) begin
            levels = NUM_BUTTONS'($urandom_range(0, 7));
         end else begin
            for (int b = 0; b < NUM_BUTTONS; b++)
               if ($urandom_range(0, 3) == 0)
                  levels[b] = ~levels[b];
         end
         reach = cfg_debounce + cfg_hold + cfg_lockout;
         pick = $urandom_range(0, 19);
         if (pick < 8)
            poll_clock_ms += $urandom_range(0, cfg_debounce);
         else if (pick < 16)
            poll_clock_ms += $urandom_range(cfg_debounce, reach);
         else if (pick == 18)
            poll_clock_ms = $urandom();
         else if (pick == 19)
            poll_clock_ms += $urandom_range(0, 32'h0001_0000);
         send_poll(levels, poll_clock_ms);
      end
   endtask

   // The receiver holds off while every other poll releases all three buttons.
   task automatic test_backpressure();
      set_idling(0, 0);
      write_reg(CSR_DEBOUNCE, 16'd0);
      write_reg(CSR_LOCK_EN, 16'd0);
      write_reg(CSR_HOLD_EN, 16'd0);
      hold_off_ticket++;
      for (int i = 0; i < 30; i++) begin
         poll_clock_ms += 1;
         send_poll((i % 2 == 0) ? 3'b000 : 3'b111, poll_clock_ms);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_lockout_after_reset();
      test_hold_and_click();
      test_suppressed_hold();
      test_time_wrap();
      test_register_masking();
      test_random_traffic(0, 0, 72);
      test_random_traffic(54, 0, 72);
      test_random_traffic(0, 54, 72);
      test_random_traffic(14, 14, 72);
      test_backpressure();
      set_idling(14, 14);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

>>> files.f
rtl/bdch_pkg.sv
rtl/bdch_lane.sv
rtl/bdch_merge.sv
rtl/button_debounce_click_hold.sv
rtl/bdch_checker.sv
bench/tb.sv
